// ----- rtl/pmi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types, codes and fixed-point helpers for the particle integrator.
// ----------------------------------------------------------------------------
package pmi_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned INV_MASS_W = 25;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NUM_AXES   = 3;

  // Lane multiplier: 33-bit signed by 26-bit signed (A sign-extended, B zero-extended).
  localparam int unsigned MUL_A_W = COORD_W + 1;
  localparam int unsigned MUL_B_W = INV_MASS_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned SAT_W   = PROD_W + 1;

  // 0.99 in Q0.16
  localparam logic signed [MUL_B_W-1:0] DAMP_Q16 = MUL_B_W'(64881);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 2'd3;

  // Update sequence steps
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_MUL_FORCE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ACC       = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_ACC   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_VEL       = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_DAMP  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_DAMP      = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_POS   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_POS       = 3'd7;

  typedef enum logic [1:0] {
    MODE_ADD_FORCE = 2'd0,
    MODE_MOVE      = 2'd1,
    MODE_SET_POS   = 2'd2,
    MODE_UPDATE    = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [COORD_W-1:0] vec_x;
    logic signed [COORD_W-1:0] vec_y;
    logic signed [COORD_W-1:0] vec_z;
    logic [DT_W-1:0]           time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } out_item_t;

  typedef struct packed {
    logic              en;
    mode_e             mode;
    logic [STEP_W-1:0] step;
  } lane_ctrl_t;

  localparam logic signed [SAT_W-1:0] S32_MAX = SAT_W'(2147483647);
  localparam logic signed [SAT_W-1:0] S32_MIN = ~S32_MAX;

  function automatic logic signed [SAT_W-1:0] sext(input logic signed [COORD_W-1:0] v);
    return SAT_W'(v);
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [COORD_W-1:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX[COORD_W-1:0];
    end else if (x < S32_MIN) begin
      r = S32_MIN[COORD_W-1:0];
    end else begin
      r = x[COORD_W-1:0];
    end
    return r;
  endfunction

  // Divide by 2^n, round to nearest, halves toward plus infinity.
  function automatic logic signed [SAT_W-1:0] rnd(input logic signed [PROD_W-1:0] x,
                                                  input int unsigned n);
    logic signed [SAT_W-1:0] t;
    t = SAT_W'(x) + (SAT_W'(1) <<< (n - 1));
    return t >>> n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pmi_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_lane
// One axis of the integrator: position, velocity and force state with a
// single shared multiplier stepped through the update sequence.
// ----------------------------------------------------------------------------
module pmi_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire pmi_pkg::lane_ctrl_t                   ctrl_i,
  input  wire logic signed [pmi_pkg::COORD_W-1:0]    vec_i,
  input  wire logic [pmi_pkg::DT_W-1:0]              dt_i,
  input  wire logic signed [pmi_pkg::COORD_W-1:0]    grav_i,
  input  wire logic [pmi_pkg::INV_MASS_W-1:0]        inv_mass_i,
  output logic signed [pmi_pkg::COORD_W-1:0]         pos_next_o
);

  logic signed [pmi_pkg::COORD_W-1:0] pos_q, pos_d;
  logic signed [pmi_pkg::COORD_W-1:0] vel_q, vel_d;
  logic signed [pmi_pkg::COORD_W-1:0] force_q, force_d;
  logic signed [pmi_pkg::COORD_W-1:0] acc_q, acc_d;
  logic signed [pmi_pkg::COORD_W-1:0] vn_q, vn_d;
  logic signed [pmi_pkg::PROD_W-1:0]  prod_q, prod_d;

  logic signed [pmi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pmi_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pmi_pkg::PROD_W-1:0]  prod;
  logic                               movable;

  assign movable = (inv_mass_i != '0);

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.step)
      pmi_pkg::STEP_MUL_FORCE: begin
        mul_a = pmi_pkg::MUL_A_W'(force_q);
        mul_b = {1'b0, inv_mass_i};
      end
      pmi_pkg::STEP_MUL_ACC: begin
        mul_a = pmi_pkg::MUL_A_W'(acc_q);
        mul_b = pmi_pkg::MUL_B_W'({1'b0, dt_i});
      end
      pmi_pkg::STEP_MUL_DAMP: begin
        mul_a = pmi_pkg::MUL_A_W'(vn_q);
        mul_b = pmi_pkg::DAMP_Q16;
      end
      pmi_pkg::STEP_MUL_POS: begin
        mul_a = pmi_pkg::MUL_A_W'(vn_q) + pmi_pkg::MUL_A_W'(vel_q);
        mul_b = pmi_pkg::MUL_B_W'({1'b0, dt_i});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    logic signed [pmi_pkg::COORD_W-1:0] acc_raw;
    acc_raw = '0;
    pos_d   = pos_q;
    vel_d   = vel_q;
    force_d = force_q;
    acc_d   = acc_q;
    vn_d    = vn_q;
    prod_d  = prod_q;
    if (ctrl_i.en) begin
      if (ctrl_i.mode == pmi_pkg::MODE_UPDATE) begin
        unique case (ctrl_i.step) inside
          pmi_pkg::STEP_MUL_FORCE, pmi_pkg::STEP_MUL_ACC,
          pmi_pkg::STEP_MUL_DAMP, pmi_pkg::STEP_MUL_POS: begin
            prod_d = prod;
          end
          pmi_pkg::STEP_ACC: begin
            acc_raw = pmi_pkg::sat32(pmi_pkg::rnd(prod_q, FRAC_BITS));
            // Immovable points get no gravity
            if (movable) begin
              acc_d = pmi_pkg::sat32(pmi_pkg::sext(acc_raw) + pmi_pkg::sext(grav_i));
            end else begin
              acc_d = acc_raw;
            end
          end
          pmi_pkg::STEP_VEL: begin
            vn_d = pmi_pkg::sat32(pmi_pkg::sext(vel_q) + pmi_pkg::rnd(prod_q, 16));
          end
          pmi_pkg::STEP_DAMP: begin
            vn_d = pmi_pkg::sat32(pmi_pkg::rnd(prod_q, 16));
          end
          pmi_pkg::STEP_POS: begin
            // Average of old and new velocity: extra halving folded into the shift
            pos_d   = pmi_pkg::sat32(pmi_pkg::sext(pos_q) + pmi_pkg::rnd(prod_q, 17));
            vel_d   = vn_q;
            force_d = '0;
          end
          default: begin
            prod_d = prod_q;
          end
        endcase
      end else begin
        case (ctrl_i.mode)
          pmi_pkg::MODE_ADD_FORCE: begin
            force_d = pmi_pkg::sat32(pmi_pkg::sext(force_q) + pmi_pkg::sext(vec_i));
          end
          pmi_pkg::MODE_MOVE: begin
            if (movable) begin
              pos_d = pmi_pkg::sat32(pmi_pkg::sext(pos_q) + pmi_pkg::sext(vec_i));
            end
          end
          pmi_pkg::MODE_SET_POS: begin
            pos_d = vec_i;
          end
          default: begin
            pos_d = pos_q;
          end
        endcase
      end
    end
  end

  assign pos_next_o = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vel_q   <= '0;
      force_q <= '0;
    end else begin
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      force_q <= force_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    vn_q   <= vn_d;
    prod_q <= prod_d;
  end

endmodule
`default_nettype wire

// ----- rtl/pmi_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmi_merge
// Collects the three lane positions into one result and holds it in the
// output register until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module pmi_merge (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                commit_i,
  input  wire logic signed [pmi_pkg::COORD_W-1:0]  pos_i [pmi_pkg::NUM_AXES],
  input  wire logic                                out_stall_i,
  output logic                                     out_valid_o,
  output pmi_pkg::out_item_t                       out_item_o
);

  logic               out_valid_q, out_valid_d;
  pmi_pkg::out_item_t out_item_q, out_item_d;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (commit_i) begin
      out_valid_d      = 1'b1;
      out_item_d.pos_x = pos_i[0];
      out_item_d.pos_y = pos_i[1];
      out_item_d.pos_z = pos_i[2];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ----- rtl/particle_motion_integrator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// particle_motion_integrator_top
// Fixed-point point-mass integrator with one processing lane per axis.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Add-force, move and set-position finish at
// their first step after the transfer in; an update walks the lanes through
// four chained multiplies, each on the single multiplier of its lane and each
// followed by a round-and-saturate step. The result of each item lands in an
// output register; the next item is accepted while that result waits, and an
// item finishes only once the output register is free. in_stall_o is high
// while an item is being worked on. Configuration writes take effect at the
// next edge and are meant for idle periods only.
// ----------------------------------------------------------------------------
module particle_motion_integrator_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire pmi_pkg::in_item_t                  in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output pmi_pkg::out_item_t                      out_item_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [pmi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [pmi_pkg::COORD_W-1:0]        cfg_data_i
);

  localparam logic [pmi_pkg::INV_MASS_W-1:0] InvMassOne =
    pmi_pkg::INV_MASS_W'(1 << FRAC_BITS);

  // Configuration
  logic signed [pmi_pkg::COORD_W-1:0] grav_q [pmi_pkg::NUM_AXES];
  logic [pmi_pkg::INV_MASS_W-1:0]     inv_mass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q[0]  <= '0;
      grav_q[1]  <= '0;
      grav_q[2]  <= '0;
      inv_mass_q <= InvMassOne;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmi_pkg::CFG_GRAVITY_X: grav_q[0]  <= cfg_data_i;
        pmi_pkg::CFG_GRAVITY_Y: grav_q[1]  <= cfg_data_i;
        pmi_pkg::CFG_GRAVITY_Z: grav_q[2]  <= cfg_data_i;
        pmi_pkg::CFG_INV_MASS:  inv_mass_q <= cfg_data_i[pmi_pkg::INV_MASS_W-1:0];
        default:                inv_mass_q <= inv_mass_q;
      endcase
    end
  end

  // Sequencer: holds the accepted item and walks the lanes through it
  logic                         busy_q, busy_d;
  logic [pmi_pkg::STEP_W-1:0]   step_q, step_d;
  pmi_pkg::in_item_t            item_q;
  logic                         in_xfer;
  logic                         last;
  logic                         out_free;
  logic                         commit;
  pmi_pkg::lane_ctrl_t          lane_ctrl;

  assign in_stall_o = busy_q;
  assign in_xfer    = in_valid_i && !busy_q;

  // Only updates take more than one step
  assign last     = (item_q.mode != pmi_pkg::MODE_UPDATE) || (step_q == pmi_pkg::STEP_POS);
  // The output register can take a result if empty or being drained now
  assign out_free = !out_valid_o || !out_stall_i;
  assign commit   = busy_q && last && out_free;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (in_xfer) begin
      busy_d = 1'b1;
      step_d = pmi_pkg::STEP_MUL_FORCE;
    end else if (commit) begin
      busy_d = 1'b0;
    end else if (busy_q && !last) begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= pmi_pkg::STEP_MUL_FORCE;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Capture the item on transfer; hold it while in flight
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_i;
    end
  end

  // Lanes advance on every busy cycle, except the last step waits for space
  assign lane_ctrl.en   = busy_q && (!last || out_free);
  assign lane_ctrl.mode = item_q.mode;
  assign lane_ctrl.step = step_q;

  logic signed [pmi_pkg::COORD_W-1:0] lane_vec [pmi_pkg::NUM_AXES];
  logic signed [pmi_pkg::COORD_W-1:0] lane_pos [pmi_pkg::NUM_AXES];

  assign lane_vec[0] = item_q.vec_x;
  assign lane_vec[1] = item_q.vec_y;
  assign lane_vec[2] = item_q.vec_z;

  for (genvar g = 0; g < pmi_pkg::NUM_AXES; g++) begin : g_lane
    pmi_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .vec_i      (lane_vec[g]),
      .dt_i       (item_q.time_step),
      .grav_i     (grav_q[g]),
      .inv_mass_i (inv_mass_q),
      .pos_next_o (lane_pos[g])
    );
  end

  // Merge the lane positions into the result register
  pmi_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (commit),
    .pos_i       (lane_pos),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // A finished item always shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("finished item did not reach output register");

  // An accepted item starts at the first step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> busy_q && (step_q == pmi_pkg::STEP_MUL_FORCE))
    else $error("accepted item did not start at first step");

  // Mid-update steps advance by one every cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !last |=> busy_q && (step_q == $past(step_q) + 1'b1))
    else $error("update sequence skipped or stalled a step");

  // A finished item waits while the previous result is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && last && out_valid_o && out_stall_i |=> busy_q && $stable(step_q))
    else $error("item finished into a full output register");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - particle motion integrator testbench
// Drives add-force, move, set-position and update transfers into the
// integrator and checks every returned position against an in-bench model
// of the Q16.16 integration. The run covers saturation, immovable points and
// oversized inverse masses, then random frames under changing register
// settings and three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb;
  import pmi_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam longint      Q_MAX       = 64'sd2147483647;
  localparam longint      Q_MIN       = -64'sd2147483648;
  localparam longint      DAMP_0P99   = 64'sd64881;
  localparam int          QUIET_LIMIT = 2000;

  // --------------------------------------------------------------------------
  // Block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [COORD_W-1:0]   cfg_data_i  = '0;

  particle_motion_integrator_top #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Particle model state and register shadow
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] position  [3];
  logic signed [COORD_W-1:0] velocity  [3];
  logic signed [COORD_W-1:0] force_sum [3];
  logic signed [COORD_W-1:0] gravity   [3];
  logic [INV_MASS_W-1:0]     inv_mass;

  // Positions still owed by the block, oldest first
  out_item_t expected_pos [$];

  int errors       = 0;
  int items_sent   = 0;
  int cfg_settings = 0;
  int mode_count [4];
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int snd_calm     = 0;
  int rcv_calm     = 0;
  int quiet_cycles = 0;

  out_item_t want_pos;
  string     axis_name [3] = '{"x", "y", "z"};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Fixed-point helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [COORD_W-1:0] clamp32(longint x);
    if (x > Q_MAX) begin
      return Q_MAX[COORD_W-1:0];
    end else if (x < Q_MIN) begin
      return Q_MIN[COORD_W-1:0];
    end
    return x[COORD_W-1:0];
  endfunction

  // Divide by 2^n, nearest, ties toward plus infinity
  function automatic longint round_half_up(longint x, int unsigned n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Apply one accepted transfer to the model and return the new position
  function automatic out_item_t advance_particle(in_item_t it);
    logic signed [COORD_W-1:0] v [3];
    longint    acc;
    longint    vo;
    longint    vn;
    longint    dt;
    longint    im;
    int        i;
    out_item_t r;
    v[0] = it.vec_x;
    v[1] = it.vec_y;
    v[2] = it.vec_z;
    dt   = longint'(it.time_step);
    im   = longint'(inv_mass);
    mode_count[it.mode]++;
    for (i = 0; i < 3; i++) begin
      case (it.mode)
        MODE_ADD_FORCE: begin
          force_sum[i] = clamp32(longint'(force_sum[i]) + longint'(v[i]));
        end
        MODE_MOVE: begin
          // an immovable point ignores moves
          if (im != 0) begin
            position[i] = clamp32(longint'(position[i]) + longint'(v[i]));
          end
        end
        MODE_SET_POS: begin
          position[i] = v[i];
        end
        default: begin
          acc = clamp32(round_half_up(longint'(force_sum[i]) * im, FRAC_BITS));
          if (im != 0) begin
            acc = clamp32(acc + longint'(gravity[i]));
          end
          vo = longint'(velocity[i]);
          vn = clamp32(vo + round_half_up(acc * dt, 16));
          vn = clamp32(round_half_up(vn * DAMP_0P99, 16));
          // trapezoid: average of old and new velocity over the step
          position[i]  = clamp32(longint'(position[i]) + round_half_up((vn + vo) * dt, 17));
          velocity[i]  = vn[COORD_W-1:0];
          force_sum[i] = '0;
        end
      endcase
    end
    r.pos_x = position[0];
    r.pos_y = position[1];
    r.pos_z = position[2];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random field generators
  // --------------------------------------------------------------------------
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(15))
      0:       return Q_MIN[COORD_W-1:0];
      1:       return Q_MAX[COORD_W-1:0];
      2, 3:    return $urandom;
      default: return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2, 3:    return DT_W'($urandom);
      default: return DT_W'($urandom_range(1, 16'h1000));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_gravity();
    case ($urandom_range(11))
      0:       return Q_MIN[COORD_W-1:0];
      1:       return Q_MAX[COORD_W-1:0];
      2:       return $urandom;
      3:       return '0;
      default: return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // Upper bits above the inverse mass field are junk on purpose
  function automatic logic [COORD_W-1:0] rand_inv_mass_word();
    logic [INV_MASS_W-1:0] m;
    case ($urandom_range(15))
      0, 1:    m = '0;
      2:       m = 25'h100_0000;
      3:       m = '1;
      4:       m = INV_MASS_W'($urandom_range(25'h100_0001, 25'h1FF_FFFF));
      default: m = INV_MASS_W'($urandom_range(16'h0400, 32'h0004_0000));
    endcase
    return {7'($urandom), m};
  endfunction

  // --------------------------------------------------------------------------
  // Input channel: idle per pattern, hold the transfer until accepted
  // --------------------------------------------------------------------------
  task automatic send_item(mode_e m, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y,
                           logic signed [COORD_W-1:0] z, logic [DT_W-1:0] dt);
    in_item_t it;
    it.mode      = m;
    it.vec_x     = x;
    it.vec_y     = y;
    it.vec_z     = z;
    it.time_step = dt;
    if (snd_calm != 0) begin
      snd_calm--;
    end else if ($urandom_range(63) == 0) begin
      snd_calm = $urandom_range(8, 40);
    end else begin
      while ($urandom_range(99) < snd_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    // hold the payload steady while the block stalls
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_sent++;
    expected_pos.push_back(advance_particle(it));
  endtask

  // Drop valid and wait until every owed position has come back
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_pos.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Register writes, only while the block is idle
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_GRAVITY_X: gravity[0] = data;
      CFG_GRAVITY_Y: gravity[1] = data;
      CFG_GRAVITY_Z: gravity[2] = data;
      CFG_INV_MASS:  inv_mass   = data[INV_MASS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [COORD_W-1:0] gx, logic [COORD_W-1:0] gy,
                            logic [COORD_W-1:0] gz, logic [COORD_W-1:0] im_word);
    write_reg(CFG_GRAVITY_X, gx);
    write_reg(CFG_GRAVITY_Y, gy);
    write_reg(CFG_GRAVITY_Z, gz);
    write_reg(CFG_INV_MASS, im_word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_settings++;
  endtask

  // --------------------------------------------------------------------------
  // Output channel: random stall with calm stretches
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rcv_calm != 0) begin
      rcv_calm    <= rcv_calm - 1;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(127) == 0) begin
      rcv_calm    <= $urandom_range(10, 60);
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  task automatic check_axis(int a, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: pos_%s expected %h got %h", $time, axis_name[a], want, got);
    end
  endtask

  // Compare each returned position with the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_pos.size() == 0) begin
        errors++;
        $display("%0t: unexpected position transfer %h", $time, out_item_o);
      end else begin
        want_pos = expected_pos.pop_front();
        check_axis(0, want_pos.pos_x, out_item_o.pos_x);
        check_axis(1, want_pos.pos_y, out_item_o.pos_y);
        check_axis(2, want_pos.pos_z, out_item_o.pos_z);
      end
    end
  end

  // Watchdog: end the run when no transfer moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every mode with the reset registers: unit inverse mass, no gravity
  task automatic test_basic_modes();
    send_item(MODE_SET_POS, 32'sh0001_0000, -32'sh0002_0000, 32'sh0000_0007, '1);
    send_item(MODE_MOVE, 32'sh0001_8000, 32'sh0001_8000, -32'sh0001_8000, '0);
    send_item(MODE_ADD_FORCE, 32'sh0002_0000, -32'sh0003_0000, 32'sh0000_8000, 16'h1234);
    send_item(MODE_ADD_FORCE, -32'sh0000_0001, 32'sh0000_0001, 32'sh0001_0000, '0);
    send_item(MODE_UPDATE, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0, 16'h0444);
    // no force left: velocity alone damps and moves the point
    send_item(MODE_UPDATE, '0, '0, '0, 16'h0444);
    send_item(MODE_UPDATE, '0, '0, '0, '0);
    drain_block();
  endtask

  // Push force, position and velocity into the signed 32-bit rails
  task automatic test_saturation();
    send_item(MODE_SET_POS, Q_MAX[31:0], Q_MIN[31:0], '0, '0);
    send_item(MODE_MOVE, Q_MAX[31:0], Q_MIN[31:0], Q_MIN[31:0], '1);
    send_item(MODE_ADD_FORCE, Q_MAX[31:0], Q_MIN[31:0], Q_MAX[31:0], '0);
    send_item(MODE_ADD_FORCE, Q_MAX[31:0], Q_MIN[31:0], Q_MAX[31:0], '0);
    send_item(MODE_UPDATE, '0, '0, '0, '1);
    send_item(MODE_UPDATE, '0, '0, '0, '1);
    send_item(MODE_MOVE, Q_MIN[31:0], Q_MAX[31:0], 32'sh1, '0);
    drain_block();
  endtask

  // Zero inverse mass: moves and gravity ignored, old velocity still decays
  task automatic test_immovable_point();
    set_config(32'h0000_4000, 32'hFFF6_3000, 32'h0001_0000, 32'hFE00_0000);
    send_item(MODE_MOVE, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, '0);
    send_item(MODE_ADD_FORCE, 32'sh0050_0000, -32'sh0050_0000, 32'sh0, '0);
    send_item(MODE_UPDATE, '0, '0, '0, 16'h8000);
    send_item(MODE_SET_POS, 32'sh0000_1000, 32'sh0, -32'sh0000_1000, '0);
    send_item(MODE_UPDATE, '0, '0, '0, '1);
    drain_block();
  endtask

  // Full 25-bit inverse mass with gravity at both extremes
  task automatic test_large_inv_mass();
    set_config(Q_MAX[31:0], Q_MIN[31:0], 32'h8000_0001, 32'hFFFF_FFFF);
    send_item(MODE_ADD_FORCE, 32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0100, '0);
    send_item(MODE_UPDATE, '0, '0, '0, 16'h1000);
    send_item(MODE_ADD_FORCE, Q_MAX[31:0], Q_MIN[31:0], 32'sh0000_0100, '0);
    send_item(MODE_UPDATE, '0, '0, '0, '1);
    drain_block();
  endtask

  // Random frames: forces, an occasional move or load, then an update;
  // a share of transfers is pure noise. Registers change between rounds.
  task automatic test_random_frames(int snd_pct, int rcv_pct, int n_items);
    int stop_at;
    int round_end;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    stop_at      = items_sent + n_items;
    while (items_sent < stop_at) begin
      drain_block();
      set_config(rand_gravity(), rand_gravity(), rand_gravity(), rand_inv_mass_word());
      round_end = items_sent + $urandom_range(60, 140);
      while (items_sent < round_end && items_sent < stop_at) begin
        if ($urandom_range(7) == 0) begin
          send_item(mode_e'($urandom_range(3)), $urandom, $urandom, $urandom,
                    DT_W'($urandom));
        end else begin
          repeat ($urandom_range(3)) begin
            send_item(MODE_ADD_FORCE, rand_coord(), rand_coord(), rand_coord(),
                      DT_W'($urandom));
          end
          if ($urandom_range(5) == 0) begin
            send_item(MODE_MOVE, rand_coord(), rand_coord(), rand_coord(), DT_W'($urandom));
          end
          if ($urandom_range(9) == 0) begin
            send_item(MODE_SET_POS, rand_coord(), rand_coord(), rand_coord(),
                      DT_W'($urandom));
          end
          send_item(MODE_UPDATE, $urandom, $urandom, $urandom, rand_dt());
        end
      end
    end
    drain_block();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 3; i++) begin
      position[i]  = '0;
      velocity[i]  = '0;
      force_sum[i] = '0;
      gravity[i]   = '0;
    end
    inv_mass = INV_MASS_W'(1) << FRAC_BITS;
    mode_count = '{0, 0, 0, 0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_modes();
    test_saturation();
    test_immovable_point();
    test_large_inv_mass();
    test_random_frames(34, 54, 630);
    test_random_frames(54, 34, 630);
    test_random_frames(0, 0, 630);

    // let the pipe settle before judging
    repeat (20) @(posedge clk_i);
    $display("Covered %0d transfers: %0d force adds, %0d moves, %0d loads, %0d updates",
             items_sent, mode_count[MODE_ADD_FORCE], mode_count[MODE_MOVE],
             mode_count[MODE_SET_POS], mode_count[MODE_UPDATE]);
    $display("Register settings applied: %0d, under three idle patterns", cfg_settings);
    if (errors == 0 && expected_pos.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d positions never returned", errors, expected_pos.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
